FILE: hw/rtl/lss_pkg.sv
// Shared types and codes for the lottery/SRTF slot scheduler.
// No dependencies; used by lss_alu, lss_slot_table and the top level.
package lss_pkg;

  typedef enum logic [1:0] {
    SL_EMPTY = 2'd0,
    SL_READY = 2'd1,
    SL_RUN   = 2'd2
  } slot_st_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXIT,
    S_SCAN,
    S_DIV,
    S_PICK,
    S_DEC,
    S_PREV,
    S_WIN,
    S_OUT
  } sched_state_t;

  localparam logic [1:0] MODE_CREATE = 2'd0;
  localparam logic [1:0] MODE_EXIT   = 2'd1;

  localparam logic [1:0] RS_OK   = 2'd0;
  localparam logic [1:0] RS_FULL = 2'd1;
  localparam logic [1:0] RS_NONE = 2'd2;

  localparam logic CFG_POLICY  = 1'b0;
  localparam logic CFG_QUANTUM = 1'b1;

  localparam int REM_W = 17;

  // One write into the slot table per cycle, at the index that goes with it
  typedef struct packed {
    logic             st_we;
    slot_st_t         st_val;
    logic             fill_we;
    logic [7:0]       thread;
    logic [15:0]      weight;
    logic             rem_we;
    logic [REM_W-1:0] rem;
  } tbl_wr_t;

endpackage

FILE: hw/rtl/lss_alu.sv
// Shared add/subtract unit of the slot scheduler.
// Depends on lss_pkg for the operation code.
module lss_alu #(
  parameter int W = 22
) (
  input  lss_pkg::alu_op_t op,
  input  logic [W-1:0]     a,
  input  logic [W-1:0]     b,
  output logic [W-1:0]     y
);

  always_comb begin
    case (op)
      lss_pkg::ALU_SUB: y = a - b;
      default:          y = a + b;
    endcase
  end

endmodule

FILE: hw/rtl/lss_slot_table.sv
// Thread slot table: status flags, thread ids, weights, remaining times.
// Depends on lss_pkg for the status code and the write command.
module lss_slot_table #(
  parameter int SLOTS = 8,
  parameter int IW    = 3
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [IW-1:0]               rd_idx,
  output logic [7:0]                  rd_thread,
  output logic [15:0]                 rd_weight,
  output logic [lss_pkg::REM_W-1:0]   rd_rem,
  output lss_pkg::slot_st_t           slot_st [SLOTS],
  input  logic [IW-1:0]               wr_idx,
  input  lss_pkg::tbl_wr_t            wr
);

  lss_pkg::slot_st_t          st_r     [SLOTS];
  logic [7:0]                 thread_r [SLOTS];
  logic [15:0]                weight_r [SLOTS];
  logic [lss_pkg::REM_W-1:0]  rem_r    [SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        st_r[i] <= lss_pkg::SL_EMPTY;
      end
    end else if (wr.st_we) begin
      st_r[wr_idx] <= wr.st_val;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.fill_we) begin
      thread_r[wr_idx] <= wr.thread;
      weight_r[wr_idx] <= wr.weight;
    end
    if (wr.fill_we) begin
      rem_r[wr_idx] <= lss_pkg::REM_W'(wr.weight);
    end else if (wr.rem_we) begin
      rem_r[wr_idx] <= wr.rem;
    end
  end

  assign rd_thread = thread_r[rd_idx];
  assign rd_weight = weight_r[rd_idx];
  assign rd_rem    = rem_r[rd_idx];
  assign slot_st   = st_r;

endmodule

FILE: hw/rtl/lottery_srtf_slot_scheduler.sv
// Top level of the lottery/SRTF thread slot scheduler: sequencer and registers.
// Depends on lss_pkg, lss_alu and lss_slot_table.
//
//   port group   direction  handshake          payload
//   in_*         input      in_valid/in_stall  mode target_slot thread_id weight random_value
//   out_*        output     out_valid/out_stall chosen_slot chosen_thread switched status
//   cfg_*        input      cfg_we             cfg_idx cfg_wdata
//
// Create: scan the slots for the first empty one, fill it, then register the result word.
// SRTF tick: scan for the least remaining time, decrement any winner, update, then output.
// Lottery tick: sum the weights, run a 32-bit serial modulo of the random value, pick,
// update and output; a zero total skips modulo and pick. Exit first empties a valid target.
// Sums, compares, modulo, decrement use one add/sub unit. Reset empties every slot at once.
// in_stall is high while a word is in work; a word waits in the output register
// under out_stall, and the next one finishes only once that register is free.
module lottery_srtf_slot_scheduler #(
  parameter int SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [3:0]  in_target_slot,
  input  logic [7:0]  in_thread_id,
  input  logic [15:0] in_weight,
  input  logic [31:0] in_random_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_chosen_slot,
  output logic [7:0]  out_chosen_thread,
  output logic        out_switched,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [7:0]  cfg_wdata
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TW = 16 + $clog2(SLOTS + 1);
  localparam int AW = TW + 2;
  localparam int RW = lss_pkg::REM_W;
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  lss_pkg::sched_state_t state_r, state_nxt;

  logic [IW-1:0]  idx_r, idx_nxt;
  logic [4:0]     bit_r, bit_nxt;
  logic [TW-1:0]  acc_r, acc_nxt;
  logic [TW-1:0]  rem_r, rem_nxt;
  logic           found_r, found_nxt;
  logic [IW-1:0]  win_r, win_nxt;
  logic [RW-1:0]  best_t_r, best_t_nxt;
  logic [7:0]     thr_r, thr_nxt;
  logic           sw_r, sw_nxt;
  logic           cur_valid_r, cur_valid_nxt;
  logic [IW-1:0]  cur_idx_r, cur_idx_nxt;
  logic [1:0]     mode_r, mode_nxt;
  logic [3:0]     tgt_r, tgt_nxt;
  logic [7:0]     tid_r, tid_nxt;
  logic [15:0]    w_r, w_nxt;
  logic [31:0]    rnd_r, rnd_nxt;
  logic           policy_r, policy_nxt;
  logic [7:0]     quantum_r, quantum_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [3:0]     out_slot_r, out_slot_nxt;
  logic [7:0]     out_thr_r, out_thr_nxt;
  logic           out_sw_r, out_sw_nxt;
  logic [1:0]     out_st_r, out_st_nxt;

  logic [7:0]           rd_thread;
  logic [15:0]          rd_weight;
  logic [RW-1:0]        rd_rem;
  lss_pkg::slot_st_t    slot_st [SLOTS];
  logic [IW-1:0]        wr_idx;
  lss_pkg::tbl_wr_t     wr;

  lss_pkg::alu_op_t     alu_op;
  logic [AW-1:0]        alu_a, alu_b, alu_y;
  logic                 alu_neg;

  logic                 accept, out_free, last, live, is_create;
  logic                 create_hit, srtf_take, pick_hit, sw_calc, tgt_ok;
  logic [TW-1:0]        lot_acc;
  logic [TW:0]          rem_shift;
  logic [IW-1:0]        tgt_idx;
  logic [SLOTS-1:0]     run_vec;

  lss_slot_table #(
    .SLOTS (SLOTS),
    .IW    (IW)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_idx    (idx_r),
    .rd_thread (rd_thread),
    .rd_weight (rd_weight),
    .rd_rem    (rd_rem),
    .slot_st   (slot_st),
    .wr_idx    (wr_idx),
    .wr        (wr)
  );

  lss_alu #(
    .W (AW)
  ) u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  assign in_stall  = (state_r != lss_pkg::S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign last      = (idx_r == LAST);
  assign live      = (slot_st[idx_r] == lss_pkg::SL_READY) ||
                     (slot_st[idx_r] == lss_pkg::SL_RUN);
  assign is_create = (mode_r == lss_pkg::MODE_CREATE);
  assign alu_neg   = alu_y[AW-1];

  assign create_hit = (slot_st[idx_r] == lss_pkg::SL_EMPTY);
  assign srtf_take  = live && (rd_rem != '0) && (!found_r || alu_neg);
  assign pick_hit   = live && alu_neg;
  assign lot_acc    = live ? alu_y[TW-1:0] : acc_r;
  assign rem_shift  = {rem_r, rnd_r[bit_r]};
  assign tgt_ok     = (tgt_r != 4'd0) && (5'(tgt_r) <= 5'(SLOTS));
  assign tgt_idx    = IW'(tgt_r - 4'd1);
  assign sw_calc    = (found_r != cur_valid_r) || (found_r && (win_r != cur_idx_r));

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      run_vec[i] = (slot_st[i] == lss_pkg::SL_RUN);
    end
  end

  // Operand select for the shared unit
  always_comb begin
    alu_op = lss_pkg::ALU_ADD;
    alu_a  = '0;
    alu_b  = '0;
    unique case (state_r)
      lss_pkg::S_SCAN: begin
        if (policy_r) begin
          alu_a = AW'(acc_r);
          alu_b = AW'(rd_weight);
        end else begin
          alu_op = lss_pkg::ALU_SUB;
          alu_a  = AW'(rd_rem);
          alu_b  = AW'(best_t_r);
        end
      end
      lss_pkg::S_DIV: begin
        alu_op = lss_pkg::ALU_SUB;
        alu_a  = AW'(rem_shift);
        alu_b  = AW'(acc_r);
      end
      lss_pkg::S_PICK: begin
        alu_op = lss_pkg::ALU_SUB;
        alu_a  = AW'(rem_r);
        alu_b  = AW'(rd_weight);
      end
      lss_pkg::S_DEC: begin
        alu_op = lss_pkg::ALU_SUB;
        alu_a  = AW'(best_t_r);
        alu_b  = AW'(quantum_r);
      end
      default: begin
        alu_op = lss_pkg::ALU_ADD;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lss_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = (in_mode == lss_pkg::MODE_EXIT) ? lss_pkg::S_EXIT : lss_pkg::S_SCAN;
        end
      end
      lss_pkg::S_EXIT: state_nxt = lss_pkg::S_SCAN;
      lss_pkg::S_SCAN: begin
        if (is_create) begin
          if (create_hit || last) begin
            state_nxt = lss_pkg::S_OUT;
          end
        end else if (last) begin
          if (policy_r) begin
            state_nxt = (lot_acc == '0) ? lss_pkg::S_PREV : lss_pkg::S_DIV;
          end else begin
            state_nxt = (found_r || srtf_take) ? lss_pkg::S_DEC : lss_pkg::S_PREV;
          end
        end
      end
      lss_pkg::S_DIV: begin
        if (bit_r == 5'd0) begin
          state_nxt = lss_pkg::S_PICK;
        end
      end
      lss_pkg::S_PICK: begin
        if (pick_hit || last) begin
          state_nxt = lss_pkg::S_PREV;
        end
      end
      lss_pkg::S_DEC:  state_nxt = lss_pkg::S_PREV;
      lss_pkg::S_PREV: state_nxt = lss_pkg::S_WIN;
      lss_pkg::S_WIN:  state_nxt = lss_pkg::S_OUT;
      lss_pkg::S_OUT: begin
        if (out_free) begin
          state_nxt = lss_pkg::S_IDLE;
        end
      end
      default: state_nxt = lss_pkg::S_IDLE;
    endcase
  end

  // Datapath, table writes and result word
  always_comb begin
    idx_nxt       = idx_r;
    bit_nxt       = bit_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    found_nxt     = found_r;
    win_nxt       = win_r;
    best_t_nxt    = best_t_r;
    thr_nxt       = thr_r;
    sw_nxt        = sw_r;
    cur_valid_nxt = cur_valid_r;
    cur_idx_nxt   = cur_idx_r;
    mode_nxt      = mode_r;
    tgt_nxt       = tgt_r;
    tid_nxt       = tid_r;
    w_nxt         = w_r;
    rnd_nxt       = rnd_r;
    policy_nxt    = policy_r;
    quantum_nxt   = quantum_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_slot_nxt  = out_slot_r;
    out_thr_nxt   = out_thr_r;
    out_sw_nxt    = out_sw_r;
    out_st_nxt    = out_st_r;
    wr_idx        = idx_r;
    wr            = '0;

    if (cfg_we) begin
      case (cfg_idx)
        lss_pkg::CFG_POLICY:  policy_nxt  = cfg_wdata[0];
        lss_pkg::CFG_QUANTUM: quantum_nxt = cfg_wdata;
        default:              policy_nxt  = policy_r;
      endcase
    end

    unique case (state_r)
      lss_pkg::S_IDLE: begin
        if (accept) begin
          mode_nxt   = in_mode;
          tgt_nxt    = in_target_slot;
          tid_nxt    = in_thread_id;
          w_nxt      = in_weight;
          rnd_nxt    = in_random_value;
          idx_nxt    = '0;
          acc_nxt    = '0;
          rem_nxt    = '0;
          found_nxt  = 1'b0;
          best_t_nxt = '0;
          sw_nxt     = 1'b0;
        end
      end
      lss_pkg::S_EXIT: begin
        if (tgt_ok) begin
          wr_idx    = tgt_idx;
          wr.st_we  = 1'b1;
          wr.st_val = lss_pkg::SL_EMPTY;
          wr.rem_we = 1'b1;
          wr.rem    = '0;
          if (cur_valid_r && (cur_idx_r == tgt_idx)) begin
            cur_valid_nxt = 1'b0;
          end
        end
      end
      lss_pkg::S_SCAN: begin
        idx_nxt = idx_r + 1'b1;
        if (is_create) begin
          if (create_hit) begin
            wr.st_we   = 1'b1;
            wr.st_val  = lss_pkg::SL_READY;
            wr.fill_we = 1'b1;
            wr.thread  = tid_r;
            wr.weight  = w_r;
            found_nxt  = 1'b1;
            win_nxt    = idx_r;
            thr_nxt    = tid_r;
          end
        end else if (policy_r) begin
          acc_nxt = lot_acc;
          if (last) begin
            rem_nxt = '0;
            bit_nxt = 5'd31;
            idx_nxt = '0;
          end
        end else if (srtf_take) begin
          found_nxt  = 1'b1;
          win_nxt    = idx_r;
          best_t_nxt = rd_rem;
          thr_nxt    = rd_thread;
        end
      end
      lss_pkg::S_DIV: begin
        // restoring step: keep the shifted remainder when it is below the total
        rem_nxt = alu_neg ? rem_shift[TW-1:0] : alu_y[TW-1:0];
        bit_nxt = bit_r - 5'd1;
      end
      lss_pkg::S_PICK: begin
        idx_nxt = idx_r + 1'b1;
        if (live) begin
          if (alu_neg) begin
            found_nxt = 1'b1;
            win_nxt   = idx_r;
            thr_nxt   = rd_thread;
          end else begin
            rem_nxt = alu_y[TW-1:0];
          end
        end
      end
      lss_pkg::S_DEC: begin
        wr_idx    = win_r;
        wr.rem_we = 1'b1;
        wr.rem    = (alu_neg || (alu_y == '0)) ? '0 : alu_y[RW-1:0];
      end
      lss_pkg::S_PREV: begin
        sw_nxt = sw_calc;
        wr_idx = cur_idx_r;
        if (sw_calc && cur_valid_r && (slot_st[cur_idx_r] != lss_pkg::SL_EMPTY)) begin
          wr.st_we  = 1'b1;
          wr.st_val = lss_pkg::SL_READY;
        end
      end
      lss_pkg::S_WIN: begin
        wr_idx = win_r;
        if (sw_r) begin
          cur_valid_nxt = found_r;
          cur_idx_nxt   = win_r;
          if (found_r) begin
            wr.st_we  = 1'b1;
            wr.st_val = lss_pkg::SL_RUN;
          end
        end
      end
      lss_pkg::S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_slot_nxt  = found_r ? 4'(5'(win_r) + 5'd1) : 4'd0;
          out_thr_nxt   = found_r ? thr_r : 8'd0;
          out_sw_nxt    = is_create ? 1'b0 : sw_r;
          if (found_r) begin
            out_st_nxt = lss_pkg::RS_OK;
          end else begin
            out_st_nxt = is_create ? lss_pkg::RS_FULL : lss_pkg::RS_NONE;
          end
        end
      end
      default: begin
        wr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lss_pkg::S_IDLE;
      cur_valid_r <= 1'b0;
      cur_idx_r   <= '0;
      policy_r    <= 1'b1;
      quantum_r   <= 8'd2;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      sw_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_valid_r <= cur_valid_nxt;
      cur_idx_r   <= cur_idx_nxt;
      policy_r    <= policy_nxt;
      quantum_r   <= quantum_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
      sw_r        <= sw_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    bit_r      <= bit_nxt;
    acc_r      <= acc_nxt;
    rem_r      <= rem_nxt;
    win_r      <= win_nxt;
    best_t_r   <= best_t_nxt;
    thr_r      <= thr_nxt;
    mode_r     <= mode_nxt;
    tgt_r      <= tgt_nxt;
    tid_r      <= tid_nxt;
    w_r        <= w_nxt;
    rnd_r      <= rnd_nxt;
    out_slot_r <= out_slot_nxt;
    out_thr_r  <= out_thr_nxt;
    out_sw_r   <= out_sw_nxt;
    out_st_r   <= out_st_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_chosen_slot   = out_slot_r;
  assign out_chosen_thread = out_thr_r;
  assign out_switched      = out_sw_r;
  assign out_status        = out_st_r;

  a_one_running: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(run_vec))
    else $error("more than one slot marked running");

  a_cur_is_running: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lss_pkg::S_IDLE) && cur_valid_r |-> slot_st[cur_idx_r] == lss_pkg::SL_RUN)
    else $error("current slot is not marked running");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lss_pkg::S_DIV) |-> (rem_r < acc_r))
    else $error("partial remainder not below lottery total");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == lss_pkg::S_OUT)
    else $error("result word raised outside the output step");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for lottery_srtf_slot_scheduler: directed rows, then random phases.
// Depends on lss_pkg and the scheduler RTL; predicts each result word in place.
module tb_top;

  localparam int SLOTS = 8;
  localparam logic [1:0] MODE_TICK  = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int N_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 91;
  localparam int DRAIN_CYCLES = 64;
  localparam int LONG_HOLD = 400;
  localparam int HOLD_AT_RESULT = 150;
  localparam int WATCHDOG_LIMIT = 2000;
  // policy bit above quantum, one entry per random phase
  localparam logic [8:0] PHASE_CFG [0:N_PHASES-1] = '{
    {1'b0, 8'd2}, {1'b0, 8'd1}, {1'b1, 8'd255}, {1'b0, 8'd255},
    {1'b0, 8'd0}, {1'b1, 8'd1}, {1'b0, 8'd7},   {1'b1, 8'd2}
  };
  localparam int QUIET_PHASE = 2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  target;
    logic [7:0]  thread;
    logic [15:0] weight;
    logic [31:0] rnd;
  } ev_t;

  typedef struct packed {
    logic [3:0] slot;
    logic [7:0] thread;
    logic       sw;
    logic [1:0] status;
  } sched_res_t;

  typedef struct packed {
    ev_t        ev;
    logic       typed;
    sched_res_t want;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_mode;
  logic [3:0]  in_target_slot;
  logic [7:0]  in_thread_id;
  logic [15:0] in_weight;
  logic [31:0] in_random_value;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  out_chosen_slot;
  logic [7:0]  out_chosen_thread;
  logic        out_switched;
  logic [1:0]  out_status;
  logic        cfg_we;
  logic        cfg_idx;
  logic [7:0]  cfg_wdata;

  // Predicted scheduler state
  lss_pkg::slot_st_t        tbl_st  [SLOTS];
  logic [7:0]               tbl_thr [SLOTS];
  logic [15:0]              tbl_wt  [SLOTS];
  logic [lss_pkg::REM_W-1:0] tbl_rem [SLOTS];
  int                       run_slot;
  logic                     pol_r;
  logic [7:0]               quant_r;

  sched_res_t outcomes_due [$];
  dir_row_t   dir_rows [$];
  int         fail_count;
  int         outcomes_seen;
  bit         quiet;

  lottery_srtf_slot_scheduler #(.SLOTS(SLOTS)) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_target_slot    (in_target_slot),
    .in_thread_id      (in_thread_id),
    .in_weight         (in_weight),
    .in_random_value   (in_random_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_chosen_slot   (out_chosen_slot),
    .out_chosen_thread (out_chosen_thread),
    .out_switched      (out_switched),
    .out_status        (out_status),
    .cfg_we            (cfg_we),
    .cfg_idx           (cfg_idx),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit slot_busy(int i);
    return tbl_st[i] == lss_pkg::SL_READY || tbl_st[i] == lss_pkg::SL_RUN;
  endfunction

  // Apply one event to the predicted state and return the result word it yields
  function automatic sched_res_t schedule_event(ev_t ev);
    sched_res_t  r;
    int          free_i;
    int          win;
    int          prev;
    int unsigned total;
    int unsigned acc;
    int unsigned draw;
    logic [lss_pkg::REM_W-1:0] best_t;
    r = '0;
    if (ev.mode == lss_pkg::MODE_CREATE) begin
      free_i = -1;
      for (int i = 0; i < SLOTS; i++)
        if (free_i < 0 && tbl_st[i] == lss_pkg::SL_EMPTY) free_i = i;
      if (free_i < 0) begin
        r.status = lss_pkg::RS_FULL;
        return r;
      end
      tbl_st[free_i]  = lss_pkg::SL_READY;
      tbl_thr[free_i] = ev.thread;
      tbl_wt[free_i]  = ev.weight;
      tbl_rem[free_i] = lss_pkg::REM_W'(ev.weight);
      r.slot   = 4'(free_i + 1);
      r.thread = ev.thread;
      r.status = lss_pkg::RS_OK;
      return r;
    end
    if (ev.mode == lss_pkg::MODE_EXIT && ev.target >= 1 && ev.target <= SLOTS) begin
      tbl_st[ev.target - 1]  = lss_pkg::SL_EMPTY;
      tbl_rem[ev.target - 1] = '0;
      if (run_slot == int'(ev.target)) run_slot = 0;
    end
    win = 0;
    best_t = '0;
    if (pol_r) begin
      total = 0;
      for (int i = 0; i < SLOTS; i++)
        if (slot_busy(i)) total += tbl_wt[i];
      if (total != 0) begin
        draw = ev.rnd % total + 1;
        acc = 0;
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_busy(i) && win == 0) begin
            acc += tbl_wt[i];
            if (draw <= acc) win = i + 1;
          end
        end
      end
    end else begin
      // lowest slot wins a tie; spent slots stay live but drop out
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_busy(i) && tbl_rem[i] != 0 && (win == 0 || tbl_rem[i] < best_t)) begin
          win = i + 1;
          best_t = tbl_rem[i];
        end
      end
      if (win != 0) tbl_rem[win - 1] = (best_t > quant_r) ? best_t - quant_r : '0;
    end
    prev = run_slot;
    if (win != prev) begin
      if (prev != 0 && tbl_st[prev - 1] != lss_pkg::SL_EMPTY)
        tbl_st[prev - 1] = lss_pkg::SL_READY;
      if (win != 0) tbl_st[win - 1] = lss_pkg::SL_RUN;
      run_slot = win;
    end
    r.slot   = 4'(win);
    r.thread = (win != 0) ? tbl_thr[win - 1] : 8'd0;
    r.sw     = (win != prev);
    r.status = (win != 0) ? lss_pkg::RS_OK : lss_pkg::RS_NONE;
    return r;
  endfunction

  task automatic add_row(logic [1:0] mode, logic [3:0] tgt, logic [7:0] tid,
                         logic [15:0] w, logic [31:0] rnd, logic typed,
                         logic [3:0] slot, logic [7:0] thr, logic [1:0] st);
    dir_row_t row;
    row.ev   = '{mode: mode, target: tgt, thread: tid, weight: w, rnd: rnd};
    row.typed = typed;
    row.want = '{slot: slot, thread: thr, sw: 1'b0, status: st};
    dir_rows.push_back(row);
  endtask

  task automatic make_random(output ev_t ev);
    int live_q [$];
    int pick;
    ev.mode   = MODE_TICK;
    ev.target = 4'($urandom_range(0, 15));
    ev.thread = 8'($urandom_range(0, 255));
    ev.rnd    = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 30) ev.mode = lss_pkg::MODE_CREATE;
    else if (pick < 55) ev.mode = lss_pkg::MODE_EXIT;
    else if (pick >= 95) ev.mode = MODE_SPARE;
    // mostly short jobs so SRTF slots run down to zero
    pick = $urandom_range(0, 99);
    if (pick < 60) ev.weight = 16'($urandom_range(1, 40));
    else if (pick < 85) ev.weight = 16'($urandom_range(1, 1000));
    else if (pick < 97) ev.weight = 16'($urandom_range(0, 65535));
    else ev.weight = '0;
    for (int i = 0; i < SLOTS; i++)
      if (slot_busy(i)) live_q.push_back(i + 1);
    if (ev.mode == lss_pkg::MODE_EXIT && live_q.size() != 0 && $urandom_range(0, 99) < 85)
      ev.target = 4'(live_q[$urandom_range(0, live_q.size() - 1)]);
  endtask

  // Offer one word, hold it until taken, then record the result expected for it
  task automatic drive_event(ev_t ev, logic typed, sched_res_t want);
    int gap;
    sched_res_t pred;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_mode         <= ev.mode;
    in_target_slot  <= ev.target;
    in_thread_id    <= ev.thread;
    in_weight       <= ev.weight;
    in_random_value <= ev.rnd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = schedule_event(ev);
    outcomes_due.push_back(typed ? want : pred);
  endtask

  task automatic settle();
    while (outcomes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic pol, logic [7:0] q);
    cfg_we    <= 1'b1;
    cfg_idx   <= lss_pkg::CFG_POLICY;
    cfg_wdata <= {7'($urandom_range(0, 127)), pol};
    @(posedge clk);
    cfg_idx   <= lss_pkg::CFG_QUANTUM;
    cfg_wdata <= q;
    @(posedge clk);
    cfg_we <= 1'b0;
    pol_r   = pol;
    quant_r = q;
  endtask

  task automatic check_field(string what, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      fail_count++;
      $display("%0t: %s expected %0d got %0d", $time, what, want_v, got_v);
    end
  endtask

  // Result side: check each word taken, then stall for a random stretch, none while quiet
  initial begin : result_side
    int stall_left;
    sched_res_t got;
    sched_res_t want;
    stall_left = 0;
    out_stall = 1'b0;
    outcomes_seen = 0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        got = '{slot: out_chosen_slot, thread: out_chosen_thread,
                sw: out_switched, status: out_status};
        outcomes_seen++;
        if (outcomes_due.size() == 0) begin
          fail_count++;
          $display("%0t: result slot %0d arrived with none expected", $time, got.slot);
        end else begin
          want = outcomes_due.pop_front();
          check_field("chosen_slot", 32'(want.slot), 32'(got.slot));
          check_field("chosen_thread", 32'(want.thread), 32'(got.thread));
          check_field("switched", 32'(want.sw), 32'(got.sw));
          check_field("status", 32'(want.status), 32'(got.status));
        end
        stall_left = quiet ? 0 : $urandom_range(0, 8);
        // hold off once for long enough that the input side backs up
        if (outcomes_seen == HOLD_AT_RESULT) stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    ev_t ev;
    in_valid        = 1'b0;
    in_mode         = '0;
    in_target_slot  = '0;
    in_thread_id    = '0;
    in_weight       = '0;
    in_random_value = '0;
    cfg_we          = 1'b0;
    cfg_idx         = lss_pkg::CFG_POLICY;
    cfg_wdata       = '0;
    rst_n           = 1'b0;
    quiet           = 1'b0;
    fail_count      = 0;
    run_slot        = 0;
    pol_r           = 1'b1;
    quant_r         = 8'd2;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_st[i]  = lss_pkg::SL_EMPTY;
      tbl_thr[i] = '0;
      tbl_wt[i]  = '0;
      tbl_rem[i] = '0;
    end

    // Empty table, fill every slot at the field extremes, overflow, then empty all but slot 2
    add_row(MODE_TICK, 4'd0, 8'h00, 16'h0000, 32'h0000_0000, 1'b1,
            4'd0, 8'h00, lss_pkg::RS_NONE);
    add_row(lss_pkg::MODE_EXIT, 4'd3, 8'h00, 16'h0000, 32'h0000_0001, 1'b1,
            4'd0, 8'h00, lss_pkg::RS_NONE);
    add_row(lss_pkg::MODE_CREATE, 4'd0, 8'hFF, 16'hFFFF, 32'h0000_0000, 1'b1,
            4'd1, 8'hFF, lss_pkg::RS_OK);
    add_row(lss_pkg::MODE_CREATE, 4'd0, 8'h00, 16'h0000, 32'h0000_0000, 1'b1,
            4'd2, 8'h00, lss_pkg::RS_OK);
    add_row(lss_pkg::MODE_CREATE, 4'd0, 8'h01, 16'h0001, 32'h0000_0000, 1'b1,
            4'd3, 8'h01, lss_pkg::RS_OK);
    add_row(lss_pkg::MODE_CREATE, 4'd0, 8'h80, 16'h8000, 32'h0000_0000, 1'b1,
            4'd4, 8'h80, lss_pkg::RS_OK);
    add_row(lss_pkg::MODE_CREATE, 4'd0, 8'h7F, 16'h0002, 32'h0000_0000, 1'b1,
            4'd5, 8'h7F, lss_pkg::RS_OK);
    add_row(lss_pkg::MODE_CREATE, 4'd0, 8'h30, 16'h1234, 32'h0000_0000, 1'b1,
            4'd6, 8'h30, lss_pkg::RS_OK);
    add_row(lss_pkg::MODE_CREATE, 4'd0, 8'h40, 16'h0100, 32'h0000_0000, 1'b1,
            4'd7, 8'h40, lss_pkg::RS_OK);
    add_row(lss_pkg::MODE_CREATE, 4'd0, 8'h55, 16'h7FFF, 32'h0000_0000, 1'b1,
            4'd8, 8'h55, lss_pkg::RS_OK);
    add_row(lss_pkg::MODE_CREATE, 4'd0, 8'hAA, 16'h5555, 32'h0000_0000, 1'b1,
            4'd0, 8'h00, lss_pkg::RS_FULL);
    add_row(MODE_TICK, 4'd0, 8'h00, 16'h0000, 32'h0000_0000, 1'b0,
            4'd0, 8'h00, lss_pkg::RS_OK);
    add_row(MODE_TICK, 4'd0, 8'h00, 16'h0000, 32'hFFFF_FFFF, 1'b0,
            4'd0, 8'h00, lss_pkg::RS_OK);
    add_row(MODE_SPARE, 4'd15, 8'h00, 16'h0000, 32'h1234_5678, 1'b0,
            4'd0, 8'h00, lss_pkg::RS_OK);
    add_row(lss_pkg::MODE_EXIT, 4'd0, 8'h00, 16'h0000, 32'hAAAA_AAAA, 1'b0,
            4'd0, 8'h00, lss_pkg::RS_OK);
    add_row(lss_pkg::MODE_EXIT, 4'd15, 8'h00, 16'h0000, 32'h5555_5555, 1'b0,
            4'd0, 8'h00, lss_pkg::RS_OK);
    add_row(lss_pkg::MODE_EXIT, 4'd9, 8'h00, 16'h0000, 32'h0001_0000, 1'b0,
            4'd0, 8'h00, lss_pkg::RS_OK);
    add_row(lss_pkg::MODE_EXIT, 4'd1, 8'h00, 16'h0000, 32'h0000_7777, 1'b0,
            4'd0, 8'h00, lss_pkg::RS_OK);
    for (int s = 3; s <= SLOTS; s++)
      add_row(lss_pkg::MODE_EXIT, 4'(s), 8'h00, 16'h0000, 32'(s * 977), 1'b0,
              4'd0, 8'h00, lss_pkg::RS_OK);
    // only the zero-weight slot is left: the lottery total is zero
    add_row(MODE_TICK, 4'd0, 8'h00, 16'h0000, 32'h0000_0005, 1'b0,
            4'd0, 8'h00, lss_pkg::RS_OK);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[k]) drive_event(dir_rows[k].ev, dir_rows[k].typed, dir_rows[k].want);
    in_valid <= 1'b0;

    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle();
      write_cfg(PHASE_CFG[ph][8], PHASE_CFG[ph][7:0]);
      quiet = (ph == QUIET_PHASE);
      repeat (ITEMS_PER_PHASE) begin
        make_random(ev);
        drive_event(ev, 1'b0, '0);
      end
      in_valid <= 1'b0;
    end
    quiet = 1'b0;
    settle();

    if (fail_count == 0 && outcomes_due.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/lss_pkg.sv
hw/rtl/lss_alu.sv
hw/rtl/lss_slot_table.sv
hw/rtl/lottery_srtf_slot_scheduler.sv
bench/tb_top.sv
